/* design/acal_pkg.sv */
// ----------------------------------------------------------------------------
// acal_pkg - shared types and microcode for the aging-LRU cache
// Sizes, widths, control word layout and the sequencer program ROM.
// ----------------------------------------------------------------------------
package acal_pkg;

   // sizes
   localparam int LINES        = 8;
   localparam int BLOCK_CELLS  = 4;
   localparam int MEMORY_CELLS = 128;

   // widths
   localparam int LINE_W = $clog2(LINES);
   localparam int OFF_W  = $clog2(BLOCK_CELLS);
   localparam int MEM_AW = $clog2(MEMORY_CELLS);
   localparam int TAG_W  = MEM_AW - OFF_W;
   localparam int AGE_W  = 3;
   localparam int CNT_W  = 16;
   localparam int DATA_W = 8;

   localparam logic [AGE_W-1:0] AGE_MAX   = '1;
   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   // operation codes
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // program steps
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_CLEAR  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd1;
   localparam logic [STEP_W-1:0] STEP_LOOKUP = 3'd2;
   localparam logic [STEP_W-1:0] STEP_FETCH  = 3'd3;
   localparam logic [STEP_W-1:0] STEP_LAST   = 3'd4;
   localparam logic [STEP_W-1:0] STEP_UPDATE = 3'd5;

   // jump conditions: taken jumps go to target, otherwise step + 1
   typedef enum logic [2:0] {
      JMP_NEVER,
      JMP_ALWAYS,
      JMP_NO_START,
      JMP_HIT,
      JMP_FETCH_MORE,
      JMP_CLEAR_MORE
   } jump_type;

   typedef struct packed {
      logic             clr_wr;   // write zero at cnt during clearing pass
      logic             latch;    // take request on a start transfer
      logic             lookup;   // register hit and line
      logic             mem_rd;   // read backing memory at tag, cnt
      logic             cap;      // store read data into line cell cnt-1
      logic             update;   // ages, tag, write, counters, response
      logic             cnt_inc;
      logic             cnt_clr;
      jump_type         jump;
      logic [STEP_W-1:0] target;
   } ctrl_type;

   // program ROM
   function automatic ctrl_type ucode(input logic [STEP_W-1:0] step);
      ctrl_type w;
      w = '0;
      w.jump = JMP_NEVER;
      unique case (step)
         STEP_CLEAR: begin
            w.clr_wr  = 1'b1;
            w.cnt_inc = 1'b1;
            w.jump    = JMP_CLEAR_MORE;
            w.target  = STEP_CLEAR;
         end
         STEP_IDLE: begin
            w.latch  = 1'b1;
            w.jump   = JMP_NO_START;
            w.target = STEP_IDLE;
         end
         STEP_LOOKUP: begin
            w.lookup  = 1'b1;
            w.mem_rd  = 1'b1;
            w.cnt_inc = 1'b1;
            w.jump    = JMP_HIT;
            w.target  = STEP_UPDATE;
         end
         STEP_FETCH: begin
            w.cap     = 1'b1;
            w.mem_rd  = 1'b1;
            w.cnt_inc = 1'b1;
            w.jump    = JMP_FETCH_MORE;
            w.target  = STEP_FETCH;
         end
         STEP_LAST: begin
            w.cap     = 1'b1;
            w.cnt_clr = 1'b1;
         end
         STEP_UPDATE: begin
            w.update  = 1'b1;
            w.cnt_clr = 1'b1;
            w.jump    = JMP_ALWAYS;
            w.target  = STEP_IDLE;
         end
         default: begin
            w.jump   = JMP_ALWAYS;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == COUNT_MAX) ? v : v + 1'b1;
   endfunction

endpackage

/* design/assoc_cache_aging_lru.sv */
// ----------------------------------------------------------------------------
// assoc_cache_aging_lru - fully associative cache with aging replacement
// Eight-line write-through, write-allocate cache over a byte backing memory,
// run by a microcoded sequencer: a step counter walks a control ROM.
// ----------------------------------------------------------------------------
// Flow: IDLE latches a start transfer and LOOKUP registers hit and line; a
// hit goes on to UPDATE, a miss first fetches the block from the single-port
// memory in LOOKUP, FETCH and LAST; rsp_strobe is registered from UPDATE.
// A new start is taken once rsp_strobe is high; the receiver cannot stall.
// Reset: a clearing pass zeroes all MEMORY_CELLS (128) memory cells with
// busy high; valid bits, ages and counters clear at once.
// ----------------------------------------------------------------------------
module assoc_cache_aging_lru
   import acal_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_operation,
   input  logic [MEM_AW-1:0] req_address,
   input  logic [DATA_W-1:0] req_write_data,
   output logic              rsp_strobe,
   output logic              rsp_hit,
   output logic [TAG_W-1:0]  rsp_block_number,
   output logic [LINE_W-1:0] rsp_line_index,
   output logic [OFF_W-1:0]  rsp_cell_offset,
   output logic [DATA_W-1:0] rsp_cell_value,
   output logic [CNT_W-1:0]  rsp_kind_hits,
   output logic [CNT_W-1:0]  rsp_kind_misses
);

   // sequencer
   logic [STEP_W-1:0] step_ff, step_in;
   logic [MEM_AW-1:0] cnt_ff;
   ctrl_type          cw;

   // request
   logic              op_ff;
   logic [MEM_AW-1:0] addr_ff;
   logic [DATA_W-1:0] data_ff;
   logic [TAG_W-1:0]  tag;
   logic [OFF_W-1:0]  off;

   // cache lines
   logic [LINES-1:0]  valid_ff;
   logic [TAG_W-1:0]  tag_ff   [LINES];
   logic [DATA_W-1:0] cells_ff [LINES][BLOCK_CELLS];
   logic [AGE_W-1:0]  age_ff   [LINES];

   // lookup
   logic              hit_ff, hit_c;
   logic [LINE_W-1:0] line_ff, line_c, match_idx, victim;

   // backing memory
   logic [DATA_W-1:0] mem [MEMORY_CELLS];
   logic [DATA_W-1:0] mem_q_ff;
   logic [MEM_AW-1:0] mem_addr;
   logic              mem_we;
   logic [DATA_W-1:0] mem_wd;

   // counters
   logic [CNT_W-1:0]  rd_hit_ff, rd_miss_ff, wr_hit_ff, wr_miss_ff;
   logic [CNT_W-1:0]  rd_hit_in, rd_miss_in, wr_hit_in, wr_miss_in;

   // response registers
   logic              rsp_strobe_ff, rsp_hit_ff;
   logic [TAG_W-1:0]  rsp_tag_ff;
   logic [LINE_W-1:0] rsp_line_ff;
   logic [OFF_W-1:0]  rsp_off_ff;
   logic [DATA_W-1:0] rsp_value_ff;
   logic [CNT_W-1:0]  rsp_hits_ff, rsp_misses_ff;

   assign cw   = ucode(step_ff);
   assign busy = (step_ff != STEP_IDLE);
   assign tag  = addr_ff[MEM_AW-1:OFF_W];
   assign off  = addr_ff[OFF_W-1:0];

   // hit search and victim choice
   always_comb begin
      logic             found, free;
      logic [AGE_W-1:0] best_age;
      logic [LINE_W-1:0] free_idx, best_idx;
      found     = 1'b0;
      free      = 1'b0;
      match_idx = '0;
      free_idx  = '0;
      best_idx  = '0;
      best_age  = age_ff[0];
      for (int i = 0; i < LINES; i++) begin
         if (!found && valid_ff[i] && (tag_ff[i] == tag)) begin
            found     = 1'b1;
            match_idx = LINE_W'(i);
         end
         if (!free && !valid_ff[i]) begin
            free     = 1'b1;
            free_idx = LINE_W'(i);
         end
         if (age_ff[i] > best_age) begin
            best_age = age_ff[i];
            best_idx = LINE_W'(i);
         end
      end
      hit_c  = found;
      victim = free ? free_idx : best_idx;
      line_c = found ? match_idx : victim;
   end

   // next step
   always_comb begin
      logic take;
      unique case (cw.jump)
         JMP_NEVER:      take = 1'b0;
         JMP_ALWAYS:     take = 1'b1;
         JMP_NO_START:   take = !start;
         JMP_HIT:        take = hit_c;
         JMP_FETCH_MORE: take = (cnt_ff != MEM_AW'(BLOCK_CELLS - 1));
         JMP_CLEAR_MORE: take = (cnt_ff != MEM_AW'(MEMORY_CELLS - 1));
         default:        take = 1'b0;
      endcase
      step_in = take ? cw.target : step_ff + 1'b1;
   end

   // saturating counters
   always_comb begin
      rd_hit_in  = rd_hit_ff;
      rd_miss_in = rd_miss_ff;
      wr_hit_in  = wr_hit_ff;
      wr_miss_in = wr_miss_ff;
      priority if (op_ff == OP_WRITE && hit_ff) wr_hit_in  = sat_inc(wr_hit_ff);
      else if (op_ff == OP_WRITE)               wr_miss_in = sat_inc(wr_miss_ff);
      else if (hit_ff)                          rd_hit_in  = sat_inc(rd_hit_ff);
      else                                      rd_miss_in = sat_inc(rd_miss_ff);
   end

   // memory port select
   always_comb begin
      mem_we = cw.clr_wr || (cw.update && op_ff == OP_WRITE);
      mem_wd = cw.clr_wr ? '0 : data_ff;
      priority if (cw.clr_wr) mem_addr = cnt_ff;
      else if (cw.update)     mem_addr = addr_ff;
      else                    mem_addr = {tag, cnt_ff[OFF_W-1:0]};
   end

   // backing memory, single port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wd;
      end
      mem_q_ff <= mem[mem_addr];
   end

   // sequencer and control state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= STEP_CLEAR;
         cnt_ff        <= '0;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         rd_hit_ff     <= '0;
         rd_miss_ff    <= '0;
         wr_hit_ff     <= '0;
         wr_miss_ff    <= '0;
         for (int i = 0; i < LINES; i++) begin
            age_ff[i] <= '0;
         end
      end else begin
         step_ff       <= step_in;
         rsp_strobe_ff <= cw.update;
         priority if (cw.cnt_clr) cnt_ff <= '0;
         else if (cw.cnt_inc)     cnt_ff <= cnt_ff + 1'b1;
         else                     cnt_ff <= cnt_ff;
         if (cw.update) begin
            valid_ff[line_ff] <= 1'b1;
            rd_hit_ff  <= rd_hit_in;
            rd_miss_ff <= rd_miss_in;
            wr_hit_ff  <= wr_hit_in;
            wr_miss_ff <= wr_miss_in;
            for (int i = 0; i < LINES; i++) begin
               if (LINE_W'(i) == line_ff) begin
                  age_ff[i] <= '0;
               end else if (age_ff[i] != AGE_MAX) begin
                  age_ff[i] <= age_ff[i] + 1'b1;
               end
            end
         end
      end
   end

   // request, lookup, line data and response payload
   always_ff @(posedge clock) begin
      if (cw.latch && start) begin
         op_ff   <= req_operation;
         addr_ff <= req_address;
         data_ff <= req_write_data;
      end
      if (cw.lookup) begin
         hit_ff  <= hit_c;
         line_ff <= line_c;
      end
      if (cw.cap) begin
         cells_ff[line_ff][cnt_ff[OFF_W-1:0] - 1'b1] <= mem_q_ff;
      end
      if (cw.update) begin
         tag_ff[line_ff] <= tag;
         if (op_ff == OP_WRITE) begin
            cells_ff[line_ff][off] <= data_ff;
         end
         rsp_hit_ff   <= hit_ff;
         rsp_tag_ff   <= tag;
         rsp_line_ff  <= line_ff;
         rsp_off_ff   <= off;
         rsp_value_ff <= (op_ff == OP_WRITE) ? data_ff : cells_ff[line_ff][off];
         if (op_ff == OP_WRITE) begin
            rsp_hits_ff   <= wr_hit_in;
            rsp_misses_ff <= wr_miss_in;
         end else begin
            rsp_hits_ff   <= rd_hit_in;
            rsp_misses_ff <= rd_miss_in;
         end
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_block_number = rsp_tag_ff;
   assign rsp_line_index   = rsp_line_ff;
   assign rsp_cell_offset  = rsp_off_ff;
   assign rsp_cell_value   = rsp_value_ff;
   assign rsp_kind_hits    = rsp_hits_ff;
   assign rsp_kind_misses  = rsp_misses_ff;

endmodule
